/* rtl/bgc_pkg.sv */
// Shared types, codes and the status pattern table of the barrier gate controller.
package bgc_pkg;

  // Item packing on the streaming ports.
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 24;

  // Configuration register indexes.
  localparam logic [1:0] REG_TRAVEL      = 2'd0;
  localparam logic [1:0] REG_AUTO_CLOSE  = 2'd1;
  localparam logic [1:0] REG_MAN_OCC     = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [15:0] TRAVEL_RST     = 16'd1000;
  localparam logic [15:0] AUTO_CLOSE_RST = 16'd3000;
  localparam logic [15:0] MAN_OCC_RST    = 16'd600;

  // Command codes, shared by the remote opcode and the last command.
  localparam logic [1:0] CMD_NONE       = 2'd0;
  localparam logic [1:0] CMD_OPEN_AUTO  = 2'd1;
  localparam logic [1:0] CMD_OPEN_MAN   = 2'd2;
  localparam logic [1:0] CMD_CLOSE      = 2'd3;

  // Motor relay codes.
  localparam logic [1:0] DRV_OFF   = 2'd0;
  localparam logic [1:0] DRV_OPEN  = 2'd1;
  localparam logic [1:0] DRV_CLOSE = 2'd2;

  // Status nibble symbols.
  localparam logic [3:0] DOT  = 4'h2;
  localparam logic [3:0] DASH = 4'h7;
  localparam logic [15:0] PAT_INIT = 16'hff00;

  typedef enum logic [3:0] {
    ST_INIT           = 4'd0,
    ST_CLOSED         = 4'd1,
    ST_OPENING_AUTO   = 4'd2,
    ST_REOPENING_AUTO = 4'd3,
    ST_OPEN_UNOCC     = 4'd4,
    ST_OPEN_OCC       = 4'd5,
    ST_OPEN_FREE      = 4'd6,
    ST_CLOSING_AUTO   = 4'd7,
    ST_OPENING_MAN    = 4'd8,
    ST_OPEN_MAN       = 4'd9,
    ST_OPEN_MAN_OCC   = 4'd10,
    ST_OPEN_MAN_REL   = 4'd11,
    ST_CLOSING_MAN    = 4'd12
  } gate_state_t;

  // One input item.
  typedef struct packed {
    logic [31:0] now_ms;
    logic [1:0]  opcode;
    logic        press_open_manual;
    logic        press_open_auto;
    logic        press_close;
    logic        obstacle;
  } bgc_item_t;

  // Configuration register file contents.
  typedef struct packed {
    logic [15:0] travel_time_ms;
    logic [15:0] auto_close_delay_ms;
    logic [15:0] manual_occupied_delay_ms;
  } bgc_cfg_t;

  // Controller state carried from one item to the next.
  typedef struct packed {
    gate_state_t gate;
    logic [31:0] entry_time;
    logic [31:0] free_since;
    logic [31:0] man_occ_since;
    logic [1:0]  drive;
    logic [1:0]  last_cmd;
  } bgc_state_t;

  function automatic logic [15:0] pat3(input logic [3:0] a, input logic [3:0] b,
                                       input logic [3:0] c);
    return {4'h0, a, b, c};
  endfunction

  // Dot/dash status pattern shown for each state but ST_OPEN_MAN_OCC and ST_OPEN_MAN_REL, which show zero.
  function automatic logic [15:0] pattern_of(input gate_state_t s);
    logic [15:0] p;
    case (s)
      ST_INIT:           p = PAT_INIT;
      ST_CLOSED:         p = pat3(DOT, DOT, DOT);
      ST_OPENING_AUTO:   p = pat3(DOT, DASH, DOT);
      ST_REOPENING_AUTO: p = pat3(DOT, DASH, DOT);
      ST_OPEN_UNOCC:     p = pat3(DASH, DASH, DOT);
      ST_OPEN_OCC:       p = pat3(DASH, DASH, DASH);
      ST_OPEN_FREE:      p = pat3(DASH, DOT, DASH);
      ST_CLOSING_AUTO:   p = pat3(DOT, DASH, DASH);
      ST_OPENING_MAN:    p = pat3(DOT, DOT, DASH);
      ST_OPEN_MAN:       p = pat3(DASH, DOT, DOT);
      ST_CLOSING_MAN:    p = pat3(DOT, DASH, DASH);
      default:           p = 16'h0000;
    endcase
    return p;
  endfunction

endpackage

/* rtl/barrier_gate_controller.sv */
// Top level of the parking barrier gate controller.
// Each input item is one control pass and yields exactly one result item. An item is
// registered on entry in the input register, runs through the step logic that updates the
// gate state, and lands in the result register; while the result register is stalled, the
// item waits in the input register. A new item is accepted in every cycle while the result
// side takes items, so the throughput is one item per clock. That rate is set by the state
// feedback through the step logic (three 32-bit time compares). Configuration registers
// are written through the cfg port, always ready, and must only be written while no item
// is in flight.
module barrier_gate_controller (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata, low bit up: now_ms[31:0], opcode[33:32], press_open_manual[34],
  // press_open_auto[35], press_close[36], obstacle[37], zero fill[39:38]
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [bgc_pkg::IN_DATA_W-1:0]     in_tdata,
  // out_tdata, low bit up: motor_drive[1:0], state_code[5:2], last_command[7:6],
  // status_pattern[23:8]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [bgc_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [15:0]                       cfg_data
);
  import bgc_pkg::*;

  logic       in_valid_r;
  bgc_item_t  in_item_r;
  logic       out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  bgc_state_t st_r;
  bgc_state_t st_nxt;
  bgc_cfg_t   cfg;
  logic       advance;

  assign cfg_ready = 1'b1;

  bgc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  bgc_step u_step (
    .item (in_item_r),
    .cfg  (cfg),
    .cur  (st_r),
    .nxt  (st_nxt)
  );

  // The held item moves into the result register when that register frees up.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      in_item_r.now_ms            <= in_tdata[31:0];
      in_item_r.opcode            <= in_tdata[33:32];
      in_item_r.press_open_manual <= in_tdata[34];
      in_item_r.press_open_auto   <= in_tdata[35];
      in_item_r.press_close       <= in_tdata[36];
      in_item_r.obstacle          <= in_tdata[37];
    end
  end

  // Gate state, updated once per pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.gate          <= ST_INIT;
      st_r.entry_time    <= 32'h0;
      st_r.free_since    <= 32'h0;
      st_r.man_occ_since <= 32'h0;
      st_r.drive         <= DRV_OFF;
      st_r.last_cmd      <= CMD_NONE;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (advance) begin
      out_data_r <= {pattern_of(st_nxt.gate), st_nxt.last_cmd, st_nxt.gate, st_nxt.drive};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* rtl/bgc_cfg_regs.sv */
// Configuration register file of the barrier gate controller.
module bgc_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [1:0]          wr_index,
  input  logic [15:0]         wr_data,
  output bgc_pkg::bgc_cfg_t   cfg
);
  import bgc_pkg::*;

  bgc_cfg_t cfg_r;

  // Register writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.travel_time_ms           <= TRAVEL_RST;
      cfg_r.auto_close_delay_ms      <= AUTO_CLOSE_RST;
      cfg_r.manual_occupied_delay_ms <= MAN_OCC_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_TRAVEL:     cfg_r.travel_time_ms           <= wr_data;
        REG_AUTO_CLOSE: cfg_r.auto_close_delay_ms      <= wr_data;
        REG_MAN_OCC:    cfg_r.manual_occupied_delay_ms <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/bgc_step.sv */
// One control pass: command arbitration followed by the gate state rule.
module bgc_step (
  input  bgc_pkg::bgc_item_t  item,
  input  bgc_pkg::bgc_cfg_t   cfg,
  input  bgc_pkg::bgc_state_t cur,
  output bgc_pkg::bgc_state_t nxt
);
  import bgc_pkg::*;

  logic [1:0]  cmd;
  gate_state_t g;
  logic [31:0] now;
  logic        obs;
  logic        travel_done;
  logic        free_done;
  logic        man_done;

  always_comb begin
    now = item.now_ms;
    obs = item.obstacle;

    // The remote command wins, then manual open, auto open and close buttons.
    cmd = item.opcode;
    if (cmd == CMD_NONE) begin
      if (item.press_open_manual) cmd = CMD_OPEN_MAN;
      else if (item.press_open_auto) cmd = CMD_OPEN_AUTO;
      else if (item.press_close) cmd = CMD_CLOSE;
    end

    // An accepted command moves to its start state and restarts the timer.
    nxt = cur;
    if (cmd != CMD_NONE) begin
      nxt.last_cmd   = cmd;
      nxt.entry_time = now;
      case (cmd)
        CMD_OPEN_AUTO: nxt.gate = ST_OPENING_AUTO;
        CMD_OPEN_MAN:  nxt.gate = ST_OPENING_MAN;
        default:       nxt.gate = ST_CLOSING_MAN;
      endcase
    end
    g = nxt.gate;

    // Wrapping time differences against the configured delays.
    travel_done = (now - nxt.entry_time) > {16'h0000, cfg.travel_time_ms};
    free_done   = (now - cur.free_since) > {16'h0000, cfg.auto_close_delay_ms};
    man_done    = (now - cur.man_occ_since) > {16'h0000, cfg.manual_occupied_delay_ms};

    // State rule of the state reached after the command.
    unique case (g)
      ST_CLOSED: nxt.drive = DRV_OFF;
      ST_OPENING_AUTO: begin
        if (travel_done) begin
          nxt.gate = ST_OPEN_UNOCC;  nxt.entry_time = now;
        end else nxt.drive = DRV_OPEN;
      end
      ST_REOPENING_AUTO: begin
        if (travel_done) begin
          nxt.gate = ST_OPEN_OCC;  nxt.entry_time = now;
        end else nxt.drive = DRV_OPEN;
      end
      ST_OPEN_UNOCC: begin
        if (obs) begin
          nxt.gate = ST_OPEN_OCC;  nxt.entry_time = now;
        end else nxt.drive = DRV_OFF;
      end
      ST_OPEN_OCC: begin
        if (!obs) begin
          nxt.gate = ST_OPEN_FREE;  nxt.entry_time = now;  nxt.free_since = now;
        end else nxt.drive = DRV_OFF;
      end
      ST_OPEN_FREE: begin
        if (obs) begin
          nxt.gate = ST_OPEN_OCC;  nxt.entry_time = now;
        end else if (free_done) begin
          nxt.gate = ST_CLOSING_AUTO;  nxt.entry_time = now;
        end else nxt.drive = DRV_OFF;
      end
      ST_CLOSING_AUTO: begin
        // An obstacle reverses the closing barrier.
        if (obs) begin
          nxt.gate = ST_REOPENING_AUTO;  nxt.entry_time = now;
        end else if (travel_done) begin
          nxt.gate = ST_CLOSED;  nxt.entry_time = now;
        end else nxt.drive = DRV_CLOSE;
      end
      ST_OPENING_MAN: begin
        if (travel_done) begin
          nxt.gate = ST_OPEN_MAN;  nxt.entry_time = now;
        end else nxt.drive = DRV_OPEN;
      end
      ST_OPEN_MAN: begin
        nxt.drive = DRV_OPEN;
        if (obs) begin
          nxt.man_occ_since = now;  nxt.gate = ST_OPEN_MAN_OCC;  nxt.entry_time = now;
        end
      end
      ST_OPEN_MAN_OCC: begin
        // A cleared obstacle takes precedence over the timeout.
        if (!obs) begin
          nxt.gate = ST_OPEN_MAN;  nxt.entry_time = now;
        end else if (man_done) begin
          nxt.gate = ST_OPEN_MAN_REL;  nxt.entry_time = now;
        end
      end
      ST_OPEN_MAN_REL: begin
        if (!obs) begin
          nxt.gate = ST_OPEN_MAN;  nxt.entry_time = now;
        end
      end
      ST_CLOSING_MAN: begin
        if (obs) begin
          nxt.gate = ST_OPENING_MAN;  nxt.entry_time = now;
        end else if (travel_done) begin
          nxt.gate = ST_CLOSED;  nxt.entry_time = now;
        end else nxt.drive = DRV_CLOSE;
      end
      default: nxt.drive = DRV_OFF;
    endcase
  end

endmodule

/* rtl/bgc_checker.sv */
// Port-level checks of the barrier gate controller, bound to the top level.
module bgc_port_checks (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [bgc_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [bgc_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [1:0]                     cfg_index,
  input logic [15:0]                    cfg_data
);
  import bgc_pkg::*;

  // A stalled result item holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  // Without any accepted command the gate stays in its initial state.
  a_no_cmd_init: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[7:6] == CMD_NONE |-> out_tdata[5:2] == ST_INIT)
    else $error("gate left initial state without a command");

  // The initial state shows its own pattern.
  a_init_pattern: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[5:2] == ST_INIT |-> out_tdata[23:8] == PAT_INIT)
    else $error("wrong status pattern in initial state");

  // The reported state is always one of the defined states.
  a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[5:2] <= ST_CLOSING_MAN)
    else $error("undefined state code reported");

  // Reset empties the result side.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind barrier_gate_controller bgc_port_checks u_bgc_port_checks (.*);
